>>> design/lsbp_pkg.sv
// ----------------------------------------------------------------------------
// lsbp_pkg: shared constants for the LSB-first bit packer
// Field widths of the input and result channels and the default chunk limit.
// ----------------------------------------------------------------------------
package lsbp_pkg;

    // fixed payload widths
    localparam int SRC_W    = 40;
    localparam int START_W  = 3;
    localparam int COUNT_W  = 6;
    localparam int BYTE_W   = 8;
    localparam int VALID_W  = 4;

    // default largest chunk taken from one item
    localparam int MAX_CHUNK_BITS_DEF = 32;

    // valid_bits code of a completed byte
    localparam logic [VALID_W-1:0] FULL_BYTE_BITS = 4'd8;

    // func codes
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

endpackage

>>> design/lsbp_front.sv
// ----------------------------------------------------------------------------
// lsbp_front: input classification
// Saturates the bit count and extracts the chunk of source bits to append.
// ----------------------------------------------------------------------------
module lsbp_front #(
    parameter int MAX_CHUNK_BITS = lsbp_pkg::MAX_CHUNK_BITS_DEF,
    parameter int TW             = $clog2(MAX_CHUNK_BITS + 8)
) (
    input  logic [lsbp_pkg::SRC_W-1:0]   source_bits,
    input  logic [lsbp_pkg::START_W-1:0] start_bit,
    input  logic [lsbp_pkg::COUNT_W-1:0] bit_count,
    output logic [MAX_CHUNK_BITS-1:0]    chunk,
    output logic [TW-1:0]                chunk_len
);
    import lsbp_pkg::*;

    localparam int SHW = (MAX_CHUNK_BITS > SRC_W) ? MAX_CHUNK_BITS : SRC_W;

    logic              over_limit;
    logic [SHW-1:0]    shifted;
    logic [MAX_CHUNK_BITS-1:0] len_mask;

    // count saturation
    assign over_limit = bit_count > COUNT_W'(MAX_CHUNK_BITS);
    assign chunk_len  = over_limit ? TW'(MAX_CHUNK_BITS) : TW'(bit_count);

    // align to start bit; bits above the source word read as zero
    assign shifted  = SHW'(source_bits) >> start_bit;
    assign len_mask = {MAX_CHUNK_BITS{1'b1}} >> (TW'(MAX_CHUNK_BITS) - chunk_len);
    assign chunk    = shifted[MAX_CHUNK_BITS-1:0] & len_mask;

endmodule

>>> design/lsbp_queue.sv
// ----------------------------------------------------------------------------
// lsbp_queue: two-entry queue between front and back
// Holds classified items so that input and output stall independently.
// ----------------------------------------------------------------------------
module lsbp_queue #(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          full,
    input  logic          pop,
    output logic [DW-1:0] pop_data,
    output logic          empty
);
    logic [DW-1:0] entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign pop_data = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> design/lsbp_back.sv
// ----------------------------------------------------------------------------
// lsbp_back: byte emitter
// Merges a chunk into the partial byte and emits one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module lsbp_back #(
    parameter int MAX_CHUNK_BITS = lsbp_pkg::MAX_CHUNK_BITS_DEF,
    parameter int TW             = $clog2(MAX_CHUNK_BITS + 8)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_empty,
    input  logic                          q_flush,
    input  logic [MAX_CHUNK_BITS-1:0]     q_chunk,
    input  logic [TW-1:0]                 q_len,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lsbp_pkg::BYTE_W-1:0]   m_packed_byte,
    output logic [lsbp_pkg::VALID_W-1:0]  m_valid_bits,
    output logic                          m_last_of_run
);
    import lsbp_pkg::*;

    localparam int AW = MAX_CHUNK_BITS + 7;

    logic          busy_reg;
    logic          flush_reg;
    logic [AW-1:0] acc_reg;
    logic [TW-1:0] total_reg;
    logic [6:0]    partial_reg;
    logic [2:0]    pcount_reg;

    logic                m_valid_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic [VALID_W-1:0]  nbits_reg;
    logic                last_reg;

    logic          out_free;
    logic          have_full;
    logic          have_part;
    logic          emit;
    logic [TW-1:0] rem;
    logic [AW-1:0] acc_shift;
    logic          full_last;
    logic [AW-1:0] acc_load;

    // result selection
    assign out_free  = !m_valid_reg || m_ready;
    assign have_full = total_reg >= TW'(BYTE_W);
    assign have_part = (flush_reg == FUNC_FLUSH) && (total_reg != '0) && !have_full;
    assign emit      = busy_reg && out_free && (have_full || have_part);
    assign rem       = total_reg - TW'(BYTE_W);
    assign acc_shift = acc_reg >> BYTE_W;
    assign full_last = (rem < TW'(BYTE_W)) && !((flush_reg == FUNC_FLUSH) && (rem != '0));
    assign acc_load  = AW'(partial_reg) | (AW'(q_chunk) << pcount_reg);
    assign q_pop     = !busy_reg && !q_empty;

    assign m_valid       = m_valid_reg;
    assign m_packed_byte = byte_reg;
    assign m_valid_bits  = nbits_reg;
    assign m_last_of_run = last_reg;

    // sequencer: load, emit bytes, commit the leftover partial byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            flush_reg   <= 1'b0;
            total_reg   <= '0;
            partial_reg <= '0;
            pcount_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !emit) begin
                m_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                busy_reg  <= 1'b1;
                flush_reg <= q_flush;
                acc_reg   <= acc_load;
                total_reg <= TW'(pcount_reg) + q_len;
            end else if (busy_reg) begin
                priority if (emit && have_full) begin
                    m_valid_reg <= 1'b1;
                    byte_reg    <= acc_reg[BYTE_W-1:0];
                    nbits_reg   <= FULL_BYTE_BITS;
                    last_reg    <= full_last;
                    acc_reg     <= acc_shift;
                    total_reg   <= rem;
                    if (full_last) begin
                        busy_reg    <= 1'b0;
                        partial_reg <= acc_shift[6:0];
                        pcount_reg  <= rem[2:0];
                    end
                end else if (emit) begin
                    // flushed partial byte, upper bits already zero
                    m_valid_reg <= 1'b1;
                    byte_reg    <= acc_reg[BYTE_W-1:0];
                    nbits_reg   <= VALID_W'(total_reg);
                    last_reg    <= 1'b1;
                    busy_reg    <= 1'b0;
                    partial_reg <= '0;
                    pcount_reg  <= '0;
                end else if (!have_full && !have_part) begin
                    // nothing left to emit for this item
                    busy_reg    <= 1'b0;
                    partial_reg <= (flush_reg == FUNC_FLUSH) ? 7'd0 : acc_reg[6:0];
                    pcount_reg  <= (flush_reg == FUNC_FLUSH) ? 3'd0 : total_reg[2:0];
                end else begin
                    // output register occupied: hold until it drains
                end
            end
        end
    end

    // a short byte is always the last of its run
    a_short_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (nbits_reg != FULL_BYTE_BITS) |-> last_reg)
        else $error("partial byte not marked last");

    // a flushed byte carries zeros above its valid bits
    a_short_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (nbits_reg != FULL_BYTE_BITS) |-> ((byte_reg >> nbits_reg) == '0))
        else $error("flushed byte has stray upper bits");

    // valid_bits is never zero
    a_nonzero_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (nbits_reg != '0) && (nbits_reg <= FULL_BYTE_BITS))
        else $error("bad valid_bits code");

    // emitting the last byte ends the item
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && (have_part || full_last) |=> !busy_reg)
        else $error("emitter still busy after last byte");

endmodule

>>> design/lsb_first_bit_packer_top.sv
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_top: LSB-first bit packer
// Appends variable-length bit fields to a byte stream and emits full bytes and flushed partial bytes.
// ----------------------------------------------------------------------------
// Each transfer appends up to MAX_CHUNK_BITS bits (count saturates there) to
// a partial-byte accumulator; every completed byte is sent out with
// valid_bits 8, and func=1 then flushes a leftover partial byte (upper bits
// zero) and clears the accumulator. The final byte caused by one item has
// last_of_run set; an item that completes and flushes nothing produces no
// output. The emitter drives one byte per cycle while the output is not
// stalled; it loads an item before emitting its result bytes and takes no
// new item until it is done with the last one. A two-entry queue behind
// the input lets new items arrive while the emitter is busy.
module lsb_first_bit_packer_top #(
    parameter int MAX_CHUNK_BITS = lsbp_pkg::MAX_CHUNK_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_func,
    input  logic [lsbp_pkg::SRC_W-1:0]     s_source_bits,
    input  logic [lsbp_pkg::START_W-1:0]   s_start_bit,
    input  logic [lsbp_pkg::COUNT_W-1:0]   s_bit_count,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lsbp_pkg::BYTE_W-1:0]    m_packed_byte,
    output logic [lsbp_pkg::VALID_W-1:0]   m_valid_bits,
    output logic                           m_last_of_run
);
    import lsbp_pkg::*;

    localparam int TW = $clog2(MAX_CHUNK_BITS + 8);
    localparam int QW = 1 + TW + MAX_CHUNK_BITS;

    logic [MAX_CHUNK_BITS-1:0] chunk;
    logic [TW-1:0]             chunk_len;
    logic                      q_full;
    logic                      q_empty;
    logic                      q_pop;
    logic [QW-1:0]             q_out;

    assign s_ready = !q_full;

    // input side
    lsbp_front #(
        .MAX_CHUNK_BITS (MAX_CHUNK_BITS),
        .TW             (TW)
    ) u_front (
        .source_bits (s_source_bits),
        .start_bit   (s_start_bit),
        .bit_count   (s_bit_count),
        .chunk       (chunk),
        .chunk_len   (chunk_len)
    );

    // decoupling queue
    lsbp_queue #(
        .DW (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && s_ready),
        .push_data ({s_func, chunk_len, chunk}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // output side
    lsbp_back #(
        .MAX_CHUNK_BITS (MAX_CHUNK_BITS),
        .TW             (TW)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_flush       (q_out[QW-1]),
        .q_chunk       (q_out[MAX_CHUNK_BITS-1:0]),
        .q_len         (q_out[QW-2:MAX_CHUNK_BITS]),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packed_byte (m_packed_byte),
        .m_valid_bits  (m_valid_bits),
        .m_last_of_run (m_last_of_run)
    );

endmodule
